### design/sha1md_pkg.sv
package sha1md_pkg;

    typedef struct packed {
        logic [31:0] message_word;
        logic [2:0]  valid_bytes;
        logic        final_word;
    } t_msg_in;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  digest_index;
        logic        last_digest;
    } t_digest_out;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam int NUM_ROUNDS  = 80;
    localparam int BLOCK_WORDS = 16;
    localparam int DIGEST_LEN  = 5;

    // Initial chaining value for digest position idx.
    function automatic logic [31:0] init_chain(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0:    v = H0_INIT;
            3'd1:    v = H1_INIT;
            3'd2:    v = H2_INIT;
            3'd3:    v = H3_INIT;
            default: v = H4_INIT;
        endcase
        return v;
    endfunction

endpackage

### design/sha1_message_digest.sv
// SHA-1 digest engine. The message arrives as big-endian 32-bit words on the
// input channel; every word carries four bytes except the one marked final,
// which carries 0 to 4 leading bytes (counts above four are taken as four).
// When the final word has been taken, the engine appends the 0x80 marker,
// zero fill and the 64-bit bit length, compresses what remains, and then
// offers the five digest words H0 to H4 on the output channel, index 0 first,
// with last_digest set on the fifth. After the fifth word has been taken the
// chaining values and byte count return to their initial state, ready for the
// next message. An ordinary word is taken whenever the engine is idle; the word
// that fills a 16-word block starts a compression: 80 rounds of one shared
// round unit, one round per cycle, and then a step that adds the working
// variables into the chaining values. After the final word the padding words
// are written one per cycle, and each further block is compressed the same
// way, before the digest is offered. While the engine is busy or presenting
// the digest, o_stall is high.
module sha1_message_digest
    import sha1md_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  t_msg_in     i_word,
    output logic        o_valid,
    input  logic        i_stall,
    output t_digest_out o_digest
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PAD   = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    localparam logic [6:0] LAST_ROUND = 7'(NUM_ROUNDS - 1);
    localparam logic [2:0] LAST_IDX   = 3'(DIGEST_LEN - 1);

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_slot, n_slot;
    logic [6:0]  r_round, n_round;
    logic [2:0]  r_idx, n_idx;
    logic [63:0] r_bytes, n_bytes;
    logic        r_padding, n_padding;
    logic        r_need80, n_need80;
    logic        r_len_hi, n_len_hi;
    logic        r_len_done, n_len_done;

    logic [31:0] r_chain [DIGEST_LEN];
    logic [31:0] r_a, r_b, r_c, r_d, r_e;
    logic [31:0] r_w [BLOCK_WORDS];

    logic        in_acc, out_acc;
    logic        put_en;
    logic [31:0] put_word;
    logic [2:0]  cnt;
    logic [31:0] tail_word;
    logic        round_en;
    logic [31:0] w_exp, w_t, f_val, k_val, tmp;
    logic        load_vars;

    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;
    assign o_stall = (r_state != S_IDLE);
    assign o_valid = (r_state == S_OUT);

    assign o_digest.digest_word  = r_chain[r_idx];
    assign o_digest.digest_index = r_idx;
    assign o_digest.last_digest  = (r_idx == LAST_IDX);

    // Byte count of the accepted word: four unless it is the final word,
    // where anything above four saturates.
    always_comb begin
        if (!i_word.final_word || i_word.valid_bytes > 3'd4) begin
            cnt = 3'd4;
        end else begin
            cnt = i_word.valid_bytes;
        end
    end

    // Final word with fewer than four bytes: keep the leading bytes and place
    // the end marker straight after them.
    always_comb begin
        case (cnt)
            3'd0:    tail_word = PAD_WORD;
            3'd1:    tail_word = {i_word.message_word[31:24], 24'h800000};
            3'd2:    tail_word = {i_word.message_word[31:16], 16'h8000};
            3'd3:    tail_word = {i_word.message_word[31:8], 8'h80};
            default: tail_word = i_word.message_word;
        endcase
    end

    // Word written into the block buffer this cycle, if any.
    always_comb begin
        put_en   = 1'b0;
        put_word = 32'd0;
        case (r_state)
            S_IDLE: begin
                put_en   = in_acc;
                put_word = tail_word;
            end
            S_PAD: begin
                put_en = 1'b1;
                if (r_need80) begin
                    put_word = PAD_WORD;
                end else if (r_len_hi) begin
                    put_word = {r_bytes[28:0], 3'b000};
                end else if (r_slot != 4'd14) begin
                    put_word = 32'd0;
                end else begin
                    put_word = r_bytes[60:29];
                end
            end
            default: begin
                put_en   = 1'b0;
                put_word = 32'd0;
            end
        endcase
    end

    assign round_en  = (r_state == S_ROUND);
    assign load_vars = put_en && (r_slot == 4'd15);

    // Shared round unit. The schedule is a 16-deep shift line: tap 0 holds
    // W[t-16], tap 13 W[t-3], tap 8 W[t-8] and tap 2 W[t-14].
    always_comb begin
        w_exp = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
        w_t   = (r_round < 7'd16) ? r_w[0] : {w_exp[30:0], w_exp[31]};
        if (r_round < 7'd20) begin
            f_val = r_d ^ (r_b & (r_c ^ r_d));
            k_val = K_R0;
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_R1;
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) | (r_d & (r_b | r_c));
            k_val = K_R2;
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = K_R3;
        end
        tmp = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + w_t;
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_round    = r_round;
        n_idx      = r_idx;
        n_bytes    = r_bytes;
        n_padding  = r_padding;
        n_need80   = r_need80;
        n_len_hi   = r_len_hi;
        n_len_done = r_len_done;

        if (put_en) begin
            n_slot = r_slot + 4'd1;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_bytes = r_bytes + {61'd0, cnt};
                    if (i_word.final_word) begin
                        n_padding = 1'b1;
                        n_need80  = (cnt == 3'd4);
                    end
                    if (load_vars) begin
                        n_state = S_ROUND;
                        n_round = 7'd0;
                    end else if (i_word.final_word) begin
                        n_state = S_PAD;
                    end
                end
            end
            S_PAD: begin
                if (r_need80) begin
                    n_need80 = 1'b0;
                end else if (r_len_hi) begin
                    n_len_hi   = 1'b0;
                    n_len_done = 1'b1;
                end else if (r_slot == 4'd14) begin
                    n_len_hi = 1'b1;
                end
                if (load_vars) begin
                    n_state = S_ROUND;
                    n_round = 7'd0;
                end
            end
            S_ROUND: begin
                n_round = r_round + 7'd1;
                if (r_round == LAST_ROUND) begin
                    n_state = S_ADD;
                    n_round = 7'd0;
                end
            end
            S_ADD: begin
                if (r_len_done) begin
                    n_state = S_OUT;
                    n_idx   = 3'd0;
                end else if (r_padding) begin
                    n_state = S_PAD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_OUT: begin
                if (out_acc) begin
                    n_idx = r_idx + 3'd1;
                    if (r_idx == LAST_IDX) begin
                        n_state    = S_IDLE;
                        n_idx      = 3'd0;
                        n_bytes    = 64'd0;
                        n_slot     = 4'd0;
                        n_padding  = 1'b0;
                        n_need80   = 1'b0;
                        n_len_hi   = 1'b0;
                        n_len_done = 1'b0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_slot     <= 4'd0;
            r_round    <= 7'd0;
            r_idx      <= 3'd0;
            r_bytes    <= 64'd0;
            r_padding  <= 1'b0;
            r_need80   <= 1'b0;
            r_len_hi   <= 1'b0;
            r_len_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_round    <= n_round;
            r_idx      <= n_idx;
            r_bytes    <= n_bytes;
            r_padding  <= n_padding;
            r_need80   <= n_need80;
            r_len_hi   <= n_len_hi;
            r_len_done <= n_len_done;
        end
    end

    // Chaining values: initial on reset and after the digest has gone out,
    // accumulated after every compression.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DIGEST_LEN; i++) begin
            if (!i_rst_n) begin
                r_chain[i] <= init_chain(3'(i));
            end else if (r_state == S_OUT && out_acc && r_idx == LAST_IDX) begin
                r_chain[i] <= init_chain(3'(i));
            end
        end
        if (i_rst_n && r_state == S_ADD) begin
            r_chain[0] <= r_chain[0] + r_a;
            r_chain[1] <= r_chain[1] + r_b;
            r_chain[2] <= r_chain[2] + r_c;
            r_chain[3] <= r_chain[3] + r_d;
            r_chain[4] <= r_chain[4] + r_e;
        end
    end

    // Working variables.
    always_ff @(posedge i_clk) begin
        if (load_vars) begin
            r_a <= r_chain[0];
            r_b <= r_chain[1];
            r_c <= r_chain[2];
            r_d <= r_chain[3];
            r_e <= r_chain[4];
        end else if (round_en) begin
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= tmp;
        end
    end

    // Block buffer and schedule shift line.
    always_ff @(posedge i_clk) begin
        if (put_en || round_en) begin
            for (int k = 0; k < BLOCK_WORDS - 1; k++) begin
                r_w[k] <= r_w[k + 1];
            end
            r_w[BLOCK_WORDS - 1] <= put_en ? put_word : w_t;
        end
    end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps

// Testbench for the SHA-1 digest engine.
//
// Message words go in on the input channel and the five digest words come out
// on the output channel. A predictor in this file keeps its own copy of the
// block buffer, chaining values, byte total and buffer slot. It works out the
// digest whenever a final word is accepted and queues the five expected digest
// words. Each digest word accepted from the engine is checked, field by field,
// against the oldest queued expectation.
//
// The stimulus starts with a short table of directed words. It then sends
// random messages whose lengths cluster around the block boundaries, so that
// the padding sometimes needs an extra block. Both sides idle at random,
// except during one long calm stretch in the middle of the random part.
module tb_top;
    import sha1md_pkg::*;

    localparam int RANDOM_WORDS = 440;
    localparam int IDLE_PERCENT = 36;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 400000;

    // Known digests of the empty message and of "abc", H0 in the top bits.
    localparam logic [159:0] EMPTY_DIGEST =
        160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709;
    localparam logic [159:0] ABC_DIGEST =
        160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d;

    // One row of the directed table. Where known is set, the digest that
    // the row completes is typed in rather than taken from the predictor.
    typedef struct packed {
        t_msg_in      w;
        logic         known;
        logic [159:0] digest;
    } t_stim_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        i_stall = 1'b0;
    t_msg_in     i_word  = '0;
    logic        o_stall;
    logic        o_valid;
    t_digest_out o_digest;

    // Predictor state: the 16-word block buffer, the running chaining values,
    // the byte total of the current message and the next free buffer slot.
    logic [31:0] block_buf [BLOCK_WORDS];
    logic [31:0] chain [DIGEST_LEN];
    logic [63:0] byte_total;
    logic [3:0]  block_slot;

    t_digest_out digest_queue [$];
    t_digest_out expected_word;

    // While calm is set neither side idles.
    logic calm        = 1'b0;
    int   words_sent  = 0;
    int   fail_count  = 0;
    int   cycle_count = 0;

    sha1_message_digest i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_word   (i_word),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_digest (o_digest)
    );

    always #1 i_clk = ~i_clk;

    // Eighty rounds over the block buffer. The schedule is expanded in place,
    // with the one-bit rotate, as the rounds go past the sixteenth.
    task automatic compress_block();
        logic [31:0] a, b, c, d, e, f, k, w, t;
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < NUM_ROUNDS; r++) begin
            if (r < BLOCK_WORDS) begin
                w = block_buf[r];
            end else begin
                w = block_buf[r % 16] ^ block_buf[(r - 14) % 16]
                  ^ block_buf[(r - 8) % 16] ^ block_buf[(r - 3) % 16];
                w = {w[30:0], w[31]};
                block_buf[r % 16] = w;
            end
            if (r < 20) begin
                f = d ^ (b & (c ^ d));
                k = K_R0;
            end else if (r < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (r < 60) begin
                f = (b & c) | (d & (b | c));
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain[0] = chain[0] + a;
        chain[1] = chain[1] + b;
        chain[2] = chain[2] + c;
        chain[3] = chain[3] + d;
        chain[4] = chain[4] + e;
    endtask

    // Puts one word into the buffer and compresses once the block is full.
    task automatic load_block_word(input logic [31:0] w);
        block_buf[block_slot] = w;
        block_slot = block_slot + 4'd1;
        if (block_slot == 4'd0) begin
            compress_block();
        end
    endtask

    task automatic restart_message();
        chain[0]   = H0_INIT;
        chain[1]   = H1_INIT;
        chain[2]   = H2_INIT;
        chain[3]   = H3_INIT;
        chain[4]   = H4_INIT;
        byte_total = '0;
        block_slot = '0;
    endtask

    // Takes one accepted message word. On a final word it pads the message,
    // appends the bit length and queues the five digest words.
    task automatic predict_word(input t_msg_in w, input logic known,
                                input logic [159:0] typed);
        int unsigned count;
        logic [31:0] keep;
        logic [31:0] marker;
        t_digest_out res;
        if (!w.final_word) begin
            // The byte count of an ordinary word is ignored: such a word always carries four bytes.
            byte_total = byte_total + 64'd4;
            load_block_word(w.message_word);
        end else begin
            count = (w.valid_bytes > 3'd4) ? 4 : w.valid_bytes;
            if (count == 4) begin
                load_block_word(w.message_word);
                load_block_word(PAD_WORD);
            end else begin
                // Bytes past the count are dropped and the 0x80 marker follows
                // the last kept byte.
                keep   = (count == 0) ? 32'h0 : (32'hFFFF_FFFF << (32 - 8 * count));
                marker = 32'h80 << (24 - 8 * count);
                load_block_word((w.message_word & keep) | marker);
            end
            byte_total = byte_total + 64'(count);
            // No room left for the length: zero-fill into an extra block.
            if (block_slot > 4'd14) begin
                while (block_slot != 4'd0) begin
                    load_block_word(32'h0);
                end
            end
            while (block_slot < 4'd14) begin
                load_block_word(32'h0);
            end
            load_block_word(byte_total[60:29]);
            load_block_word({byte_total[28:0], 3'b000});
            for (int i = 0; i < DIGEST_LEN; i++) begin
                res.digest_word  = known ? typed[159 - 32 * i -: 32] : chain[i];
                res.digest_index = i[2:0];
                res.last_digest  = (i == DIGEST_LEN - 1);
                digest_queue.push_back(res);
            end
            restart_message();
        end
    endtask

    // Offers one word, possibly after random idle cycles, and holds it until the
    // engine takes it. Valid stays high from one word to the next where there
    // is no idle cycle between them.
    task automatic send_word(input t_msg_in w, input logic known,
                             input logic [159:0] typed);
        while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        predict_word(w, known, typed);
        words_sent++;
    endtask

    function automatic t_stim_row stim_row(input logic [31:0] word,
                                           input logic [2:0] count,
                                           input logic last,
                                           input logic known,
                                           input logic [159:0] digest);
        t_stim_row row;
        row.w.message_word = word;
        row.w.valid_bytes  = count;
        row.w.final_word   = last;
        row.known          = known;
        row.digest         = digest;
        return row;
    endfunction

    // The receiving side stalls at random outside the calm stretch.
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
    end

    // Every digest word that the engine hands over is checked against the
    // oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_queue.size() == 0) begin
                if (fail_count < REPORT_LIMIT) begin
                    $display("unexpected digest word %h index %0d last %b",
                             o_digest.digest_word, o_digest.digest_index,
                             o_digest.last_digest);
                end
                fail_count++;
            end else begin
                expected_word = digest_queue.pop_front();
                if (o_digest.digest_word  !== expected_word.digest_word  ||
                    o_digest.digest_index !== expected_word.digest_index ||
                    o_digest.last_digest  !== expected_word.last_digest) begin
                    if (fail_count < REPORT_LIMIT) begin
                        $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                                 expected_word.digest_word, expected_word.digest_index,
                                 expected_word.last_digest, o_digest.digest_word,
                                 o_digest.digest_index, o_digest.last_digest);
                    end
                    fail_count++;
                end
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_stim_row rows [$];
        t_msg_in   w;
        int        body_len;
        int        pick;
        int        random_start;

        restart_message();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: the empty message and "abc" with their known
        // digests, an all-ones final word with a count above four, ordinary
        // words with counts of zero and above four, a final word whose
        // dropped bytes are not zero, a single full final word, and a message
        // whose final word lands in slot fourteen so that the length needs
        // an extra block.
        rows.push_back(stim_row(32'h0000_0000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST));
        rows.push_back(stim_row(32'h6162_6300, 3'd3, 1'b1, 1'b1, ABC_DIGEST));
        rows.push_back(stim_row(32'hFFFF_FFFF, 3'd7, 1'b1, 1'b0, '0));
        rows.push_back(stim_row(32'h0000_0000, 3'd0, 1'b0, 1'b0, '0));
        rows.push_back(stim_row(32'hFFFF_FFFF, 3'd5, 1'b0, 1'b0, '0));
        rows.push_back(stim_row(32'hABFF_FFFF, 3'd1, 1'b1, 1'b0, '0));
        rows.push_back(stim_row(32'h1234_5678, 3'd4, 1'b1, 1'b0, '0));
        for (int i = 0; i < 14; i++) begin
            rows.push_back(stim_row(32'h0101_0101 * (i + 1), 3'(i % 8), 1'b0,
                                    1'b0, '0));
        end
        rows.push_back(stim_row(32'hA5A5_FFFF, 3'd2, 1'b1, 1'b0, '0));

        foreach (rows[j]) begin
            send_word(rows[j].w, rows[j].known, rows[j].digest);
        end

        // Random messages. Most are short, some straddle the two-block
        // boundary and a few run to five blocks. Every message ends in a
        // final word, so the stimulus always stops on a complete digest.
        random_start = words_sent;
        while (words_sent - random_start < RANDOM_WORDS) begin
            calm <= (words_sent - random_start > 180) &&
                    (words_sent - random_start < 300);
            pick = $urandom_range(0, 9);
            if (pick < 6) begin
                body_len = $urandom_range(0, 17);
            end else if (pick < 9) begin
                body_len = $urandom_range(26, 34);
            end else begin
                body_len = $urandom_range(40, 64);
            end
            for (int k = 0; k <= body_len; k++) begin
                case ($urandom_range(0, 7))
                    0:       w.message_word = 32'h0000_0000;
                    1:       w.message_word = 32'hFFFF_FFFF;
                    default: w.message_word = $urandom;
                endcase
                w.valid_bytes = 3'($urandom_range(0, 7));
                w.final_word  = (k == body_len);
                send_word(w, 1'b0, '0);
            end
        end
        i_valid <= 1'b0;

        // Wait for the outstanding digests, then watch for stray words.
        while (digest_queue.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
